@@ src/rac_pkg.sv @@
// ----------------------------------------------------------------------------
// rac_pkg
// Shared widths, codes and handshake types for the RSSI average / calibrate /
// percent block and its shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package rac_pkg;

  localparam int SAMPLE_W            = 10;
  localparam int SAMPLES_PER_READING = 100;
  localparam int LEVEL_W             = 11;
  localparam int PCT_W               = 7;
  localparam int MODE_W              = 2;

  localparam int SUM_W  = $clog2(SAMPLES_PER_READING * ((1 << SAMPLE_W) - 1) + 1);
  localparam int CNT_W  = $clog2(SAMPLES_PER_READING + 1);
  localparam int PNUM_W = $clog2(((1 << LEVEL_W) - 1) * 100 + 1);
  localparam int DIVD_W = (SUM_W > PNUM_W) ? SUM_W : PNUM_W;
  localparam int DIVS_W = LEVEL_W;

  // divider step counter
  localparam int                    DIV_STEP_W    = $clog2(DIVD_W);
  localparam logic [DIV_STEP_W-1:0] DIV_STEP_LAST = DIV_STEP_W'(DIVD_W - 1);

  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = {LEVEL_W{1'b1}};
  localparam logic [LEVEL_W-1:0] LEVEL_OFFSET = LEVEL_W'(200);
  localparam logic [LEVEL_W-1:0] MAX_SPAN     = LEVEL_W'(100);
  localparam logic [PCT_W-1:0]   PCT_FULL     = PCT_W'(100);

  // calibration modes
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MIN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MAX  = 2'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_SMIN  = 2'd1;
  localparam logic [1:0] REG_SMAX  = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } rac_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quot;
  } rac_div_rsp_t;

endpackage

`default_nettype wire

@@ src/rac_div.sv @@
// ----------------------------------------------------------------------------
// rac_div
// Restoring divider, one quotient bit per cycle, shared by the block-end
// average and the percent mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module rac_div (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rac_pkg::rac_div_req_t req,
  output rac_pkg::rac_div_rsp_t     rsp
);
  import rac_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_STEP_W-1:0] step_r;
  logic [DIVD_W-1:0]     quo_r;
  logic [DIVD_W-1:0]     quo_nxt;
  logic [DIVS_W-1:0]     rem_r;
  logic [DIVS_W-1:0]     rem_nxt;
  logic [DIVS_W-1:0]     dvs_r;
  logic [DIVS_W:0]       rem_sh;
  logic                  fits;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIVD_W-1]};
    fits    = rem_sh >= {1'b0, dvs_r};
    rem_nxt = fits ? DIVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DIVS_W-1:0];
    quo_nxt = {quo_r[DIVD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r & ~req.start & (step_r == DIV_STEP_LAST);
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        quo_r  <= quo_nxt;
        rem_r  <= rem_nxt;
        step_r <= step_r + DIV_STEP_W'(1);
        if (step_r == DIV_STEP_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

`default_nettype wire

@@ src/rssi_average_calibrate_percent.sv @@
// ----------------------------------------------------------------------------
// rssi_average_calibrate_percent
// Block average of converter samples, min/max self-calibration and mapping
// of the clamped average onto 0..100 percent.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in_       input      in_valid / in_ready    in_sample
//  out_      output     out_valid / out_ready  out_percent, out_min_level,
//                                              out_max_level
//  cfg (APB) input      psel/penable/pwrite    paddr, pwdata, prdata
//
//  A beat that does not close a block is added to the running sum.
//  A closing beat keeps in_ready low through two 18-step divider passes
//  (average, then percent) plus calibrate, map and result-load steps; the
//  percent pass is skipped when the bounds are equal or inverted.
//  Synchronous active-low reset loads the bounds from the reset register values.
//  A stalled result waits in the output register; a further closing beat
//  holds in the result-load step until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module rssi_average_calibrate_percent (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic [rac_pkg::SAMPLE_W-1:0] in_sample,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [rac_pkg::PCT_W-1:0]    out_percent,
  output      logic [rac_pkg::LEVEL_W-1:0]  out_min_level,
  output      logic [rac_pkg::LEVEL_W-1:0]  out_max_level,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [3:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output      logic [31:0]                  prdata,
  output      logic                         pready
);
  import rac_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_AVG  = 6'b000010,
    ST_CAL  = 6'b000100,
    ST_MAP  = 6'b001000,
    ST_PCT  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] lo;
    logic [LEVEL_W-1:0] hi;
  } bounds_t;

  function automatic bounds_t load_bounds(input logic [MODE_W-1:0]  mode,
                                          input logic [LEVEL_W-1:0] smin,
                                          input logic [LEVEL_W-1:0] smax);
    bounds_t          b;
    logic [LEVEL_W:0] sum;
    b.lo = (mode == MODE_MIN) ? '0 : smin;
    sum  = {1'b0, b.lo} + {1'b0, MAX_SPAN};
    if (mode == MODE_MAX) begin
      b.hi = sum[LEVEL_W] ? LEVEL_MAX : sum[LEVEL_W-1:0];
    end else begin
      b.hi = smax;
    end
    return b;
  endfunction

  state_t             state_r;
  logic [MODE_W-1:0]  mode_r;
  logic [LEVEL_W-1:0] smin_r;
  logic [LEVEL_W-1:0] smax_r;
  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [LEVEL_W-1:0] low_r;
  logic [LEVEL_W-1:0] high_r;
  logic [SAMPLE_W-1:0] avg_r;
  logic [PCT_W-1:0]   pct_r;
  logic               out_valid_r;
  logic [PCT_W-1:0]   out_pct_r;
  logic [LEVEL_W-1:0] out_min_r;
  logic [LEVEL_W-1:0] out_max_r;

  rac_div_req_t       div_req;
  rac_div_rsp_t       div_rsp;

  logic               cfg_wr;
  logic [1:0]         cfg_idx;
  logic [MODE_W-1:0]  mode_w;
  logic [LEVEL_W-1:0] smin_w;
  logic [LEVEL_W-1:0] smax_w;
  bounds_t            ld;

  logic               in_fire;
  logic [SUM_W-1:0]   sum_add;
  logic               blk_end;

  logic [LEVEL_W-1:0] avg_l;
  logic [LEVEL_W-1:0] lo_a;
  logic [LEVEL_W-1:0] lo_off;
  logic [LEVEL_W-1:0] lo_mid;
  logic [LEVEL_W-1:0] low_cal;
  logic [LEVEL_W-1:0] high_cal;
  logic [LEVEL_W-1:0] clamp_c;
  logic [LEVEL_W-1:0] span;
  logic [DIVD_W-1:0]  pnum;

  // ---- config port ----
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    mode_w = (cfg_idx == REG_MODE) ? pwdata[MODE_W-1:0]  : mode_r;
    smin_w = (cfg_idx == REG_SMIN) ? pwdata[LEVEL_W-1:0] : smin_r;
    smax_w = (cfg_idx == REG_SMAX) ? pwdata[LEVEL_W-1:0] : smax_r;
    ld     = load_bounds(mode_w, smin_w, smax_w);
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_MODE: prdata = 32'(mode_r);
      REG_SMIN: prdata = 32'(smin_r);
      REG_SMAX: prdata = 32'(smax_r);
      default:  prdata = '0;
    endcase
  end

  // ---- accumulate ----
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign sum_add  = sum_r + SUM_W'(in_sample);
  assign blk_end  = (cnt_r == CNT_W'(SAMPLES_PER_READING - 1));

  // ---- calibration ----
  always_comb begin
    avg_l    = LEVEL_W'(avg_r);
    lo_a     = (low_r == '0) ? avg_l + LEVEL_OFFSET : low_r;
    lo_off   = lo_a - LEVEL_OFFSET;
    lo_mid   = LEVEL_W'(({1'b0, lo_off} + {1'b0, avg_l}) >> 1) + LEVEL_OFFSET;
    low_cal  = low_r;
    high_cal = high_r;
    if (mode_r == MODE_MIN) begin
      low_cal = ((lo_a >= LEVEL_OFFSET) && (lo_off > avg_l)) ? lo_mid : lo_a;
    end
    if (mode_r == MODE_MAX && high_r < avg_l) begin
      high_cal = avg_l;
    end
  end

  // ---- clamp and percent numerator ----
  always_comb begin
    priority if (avg_l < low_r) begin
      clamp_c = low_r;
    end else if (avg_l > high_r) begin
      clamp_c = high_r;
    end else begin
      clamp_c = avg_l;
    end
    span = high_r - low_r;
    pnum = DIVD_W'(clamp_c - low_r) * DIVD_W'(100);
  end

  // ---- sequencer ----
  always_comb begin
    div_req = '0;
    unique case (state_r)
      ST_IDLE: begin
        div_req.start    = in_fire & blk_end;
        div_req.dividend = DIVD_W'(sum_add);
        div_req.divisor  = DIVS_W'(SAMPLES_PER_READING);
      end
      ST_MAP: begin
        div_req.start    = (high_r > low_r);
        div_req.dividend = pnum;
        div_req.divisor  = span;
      end
      default: div_req = '0;
    endcase
  end

  rac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_NONE;
      smin_r      <= '0;
      smax_r      <= LEVEL_W'(1023);
      sum_r       <= '0;
      cnt_r       <= '0;
      low_r       <= '0;
      high_r      <= LEVEL_W'(1023);
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_EMIT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr && (cfg_idx == REG_MODE || cfg_idx == REG_SMIN || cfg_idx == REG_SMAX)) begin
        mode_r <= mode_w;
        smin_r <= smin_w;
        smax_r <= smax_w;
        low_r  <= ld.lo;
        high_r <= ld.hi;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (blk_end) begin
              sum_r   <= '0;
              cnt_r   <= '0;
              state_r <= ST_AVG;
            end else begin
              sum_r <= sum_add;
              cnt_r <= cnt_r + CNT_W'(1);
            end
          end
        end
        ST_AVG: begin
          if (div_rsp.done) begin
            avg_r   <= div_rsp.quot[SAMPLE_W-1:0];
            state_r <= ST_CAL;
          end
        end
        ST_CAL: begin
          low_r   <= low_cal;
          high_r  <= high_cal;
          state_r <= ST_MAP;
        end
        ST_MAP: begin
          priority if (high_r == low_r) begin
            pct_r   <= '0;
            state_r <= ST_EMIT;
          end else if (high_r < low_r) begin
            // inverted bounds: below min reads 0, otherwise full scale
            pct_r   <= (avg_l < low_r) ? '0 : PCT_FULL;
            state_r <= ST_EMIT;
          end else begin
            state_r <= ST_PCT;
          end
        end
        ST_PCT: begin
          if (div_rsp.done) begin
            pct_r   <= div_rsp.quot[PCT_W-1:0];
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_pct_r   <= pct_r;
            out_min_r   <= low_r;
            out_max_r   <= high_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_percent   = out_pct_r;
  assign out_min_level = out_min_r;
  assign out_max_level = out_max_r;

endmodule

`default_nettype wire

@@ tb/rssi_average_calibrate_percent_tb.sv @@
// ----------------------------------------------------------------------------
// rssi_average_calibrate_percent_tb
// Drives converter samples through the valid/ready input and checks every
// reading (percent, min level, max level) against an in-bench model of the
// block average, min/max self-calibration and percent mapping. Directed tests
// cover bounds, calibration modes and register reloads. Random phases then
// run mixed settings with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rssi_average_calibrate_percent_tb;
  import rac_pkg::*;

  localparam int           SETTLE_CYCLES = 64;
  localparam int           SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
  localparam logic [1:0]   REG_UNUSED    = 2'd3;
  localparam logic [1:0]   MODE_SPARE    = 2'd3;

  typedef struct packed {
    logic [PCT_W-1:0]   percent;
    logic [LEVEL_W-1:0] min_level;
    logic [LEVEL_W-1:0] max_level;
  } reading_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PCT_W-1:0]    out_percent;
  logic [LEVEL_W-1:0]  out_min_level;
  logic [LEVEL_W-1:0]  out_max_level;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  rssi_average_calibrate_percent dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_percent   (out_percent),
    .out_min_level (out_min_level),
    .out_max_level (out_max_level),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model state: registers, accumulator and calibrated bounds
  logic [MODE_W-1:0]  mode_reg = MODE_NONE;
  logic [LEVEL_W-1:0] smin_reg = '0;
  logic [LEVEL_W-1:0] smax_reg = LEVEL_W'(1023);
  int unsigned        block_sum = 0;
  int unsigned        block_count = 0;
  logic [LEVEL_W-1:0] low_bound = '0;
  logic [LEVEL_W-1:0] high_bound = LEVEL_W'(1023);

  reading_t expected_readings[$];
  int       error_count = 0;

  // sender burst shaping
  int burst_left = 0;
  int max_gap = 4;

  // receiver stall pattern
  int stall_pct = 0;
  int stall_left = 0;

  function automatic int unsigned clip_level(input int unsigned v);
    return (v > LEVEL_MAX) ? LEVEL_MAX : v;
  endfunction

  function automatic void reload_bounds();
    low_bound  = smin_reg;
    high_bound = smax_reg;
    if (mode_reg == MODE_MIN) low_bound = '0;
    if (mode_reg == MODE_MAX)
      high_bound = LEVEL_W'(clip_level(32'(low_bound) + 32'(MAX_SPAN)));
  endfunction

  function automatic void apply_register(input logic [1:0] idx, input logic [31:0] data);
    case (idx)
      REG_MODE: mode_reg = data[MODE_W-1:0];
      REG_SMIN: smin_reg = data[LEVEL_W-1:0];
      REG_SMAX: smax_reg = data[LEVEL_W-1:0];
      default: return;
    endcase
    reload_bounds();
  endfunction

  // Accumulate one beat; a block-closing beat queues the reading it produces.
  function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] s);
    int unsigned avg, lb, hb;
    longint      lo, hi, c, pct;
    reading_t    r;
    block_sum   += s;
    block_count += 1;
    if (block_count < SAMPLES_PER_READING) return;
    avg = block_sum / SAMPLES_PER_READING;
    block_sum   = 0;
    block_count = 0;
    lb = 32'(low_bound);
    hb = 32'(high_bound);
    if (mode_reg == MODE_MIN) begin
      if (lb == 0) lb = clip_level(avg + LEVEL_OFFSET);
      if (lb >= LEVEL_OFFSET && lb - LEVEL_OFFSET > avg)
        lb = clip_level((lb - LEVEL_OFFSET + avg) / 2 + LEVEL_OFFSET);
    end
    if (mode_reg == MODE_MAX && hb < avg) hb = clip_level(avg);
    low_bound  = LEVEL_W'(lb);
    high_bound = LEVEL_W'(hb);
    lo = longint'(lb);
    hi = longint'(hb);
    c  = longint'(avg);
    if (c < lo) c = lo;
    else if (c > hi) c = hi;
    if (hi == lo) begin
      pct = 0;
    end else begin
      pct = (c - lo) * 100 / (hi - lo);
      if (pct > 100 || pct < 0) pct = longint'(PCT_FULL);
    end
    r.percent   = PCT_W'(pct);
    r.min_level = low_bound;
    r.max_level = high_bound;
    expected_readings.push_back(r);
  endfunction

  function automatic void compare_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    reading_t r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected reading: expected none, actual %0d/%0d/%0d", $time,
                 out_percent, out_min_level, out_max_level);
        error_count++;
      end else begin
        r = expected_readings.pop_front();
        compare_field("percent", 32'(r.percent), 32'(out_percent));
        compare_field("min_level", 32'(r.min_level), 32'(out_min_level));
        compare_field("max_level", 32'(r.max_level), 32'(out_max_level));
      end
    end
  end

  // receiver: phases of differing stall density, including no stalls
  always @(negedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2: stall_pct = 30;
        3: stall_pct = 65;
        default: stall_pct = 92;
      endcase
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // All tasks start and end at a falling edge.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    accumulate_sample(s);
    @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int level, input int noise);
    int v;
    if (noise > SAMPLE_MAX) return SAMPLE_W'($urandom);
    v = level + $urandom_range(0, 2 * noise) - noise;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  task automatic send_samples(input int count, input int level, input int noise);
    repeat (count) send_sample(pick_sample(level, noise));
  endtask

  // hold the input, let every reading come out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // the bus goes idle after each transfer, which keeps the bus strobes single-driven
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reg_read(input logic [1:0] idx);
    logic [31:0] want;
    case (idx)
      REG_MODE: want = 32'(mode_reg);
      REG_SMIN: want = 32'(smin_reg);
      default:  want = 32'(smax_reg);
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    compare_field("register readback", want, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // upper pwdata bits carry junk to check field masking
  task automatic set_levels(input logic [1:0] mode, input int unsigned lo, input int unsigned hi);
    drain();
    reg_write(REG_SMIN, ($urandom & ~32'(LEVEL_MAX)) | lo);
    reg_write(REG_SMAX, ($urandom & ~32'(LEVEL_MAX)) | hi);
    reg_write(REG_MODE, ($urandom & ~32'(3)) | 32'(mode));
    reg_read(REG_MODE);
    reg_read(REG_SMIN);
    reg_read(REG_SMAX);
  endtask

  task automatic test_reset_defaults();
    reg_read(REG_MODE);
    reg_read(REG_SMIN);
    reg_read(REG_SMAX);
    send_samples(SAMPLES_PER_READING, 0, 0);
    send_samples(SAMPLES_PER_READING, SAMPLE_MAX, 0);
    for (int i = 0; i < SAMPLES_PER_READING; i++) send_sample(SAMPLE_W'(i[0] ? SAMPLE_MAX : 0));
  endtask

  task automatic test_equal_bounds();
    set_levels(MODE_NONE, 500, 500);
    send_samples(SAMPLES_PER_READING, 500, 0);
    send_samples(SAMPLES_PER_READING, 900, 50);
  endtask

  // min above max: below min reads 0, anything else reads full scale
  task automatic test_inverted_bounds();
    set_levels(MODE_NONE, 800, 300);
    send_samples(SAMPLES_PER_READING, 200, 0);
    send_samples(SAMPLES_PER_READING, 500, 0);
    send_samples(SAMPLES_PER_READING, 900, 0);
  endtask

  task automatic test_min_calibration();
    set_levels(MODE_MIN, 700, 1023);
    send_samples(SAMPLES_PER_READING, 300, 0);   // zero min takes avg + offset
    send_samples(SAMPLES_PER_READING, 100, 0);   // min pulled halfway down
    send_samples(SAMPLES_PER_READING, 0, 0);
    send_samples(SAMPLES_PER_READING, SAMPLE_MAX, 0);
  endtask

  task automatic test_max_calibration();
    set_levels(MODE_MAX, 100, 40);
    send_samples(SAMPLES_PER_READING, 150, 0);
    send_samples(SAMPLES_PER_READING, 700, 0);   // max raised to avg
    send_samples(SAMPLES_PER_READING, 0, 0);
  endtask

  task automatic test_level_saturation();
    set_levels(MODE_MAX, 1990, 0);               // min + span clips at full level
    send_samples(SAMPLES_PER_READING, SAMPLE_MAX, 0);
    set_levels(MODE_MAX, 32'(LEVEL_MAX), 32'(LEVEL_MAX));
    send_samples(SAMPLES_PER_READING, 0, 0);
    set_levels(MODE_NONE, 0, 32'(LEVEL_MAX));
    send_samples(SAMPLES_PER_READING, SAMPLE_MAX, 0);
  endtask

  task automatic test_spare_mode();
    set_levels(MODE_SPARE, 100, 600);
    send_samples(SAMPLES_PER_READING, 350, 100);
  endtask

  // writes reload the bounds but keep the partial block; unknown index is ignored
  task automatic test_register_reload();
    set_levels(MODE_MIN, 0, 1023);
    send_samples(SAMPLES_PER_READING, 400, 0);
    send_samples(50, 100, 0);
    drain();
    reg_write(REG_UNUSED, 32'hffff_ffff);
    send_samples(50, 100, 0);
    send_samples(30, 600, 0);
    drain();
    reg_write(REG_SMAX, 32'(900));
    send_samples(70, 600, 0);
  endtask

  task automatic test_random_phases();
    logic [1:0] mode;
    int lo, hi, total, pause_at, noise;
    for (int phase = 0; phase < 4; phase++) begin
      mode = 2'(phase);
      case ($urandom_range(0, 3))
        0: begin lo = 0; hi = 32'(LEVEL_MAX); end
        1: begin lo = $urandom_range(0, LEVEL_MAX); hi = $urandom_range(0, LEVEL_MAX); end
        default: begin lo = $urandom_range(0, 400); hi = $urandom_range(600, 1100); end
      endcase
      set_levels(mode, lo, hi);
      max_gap = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 2 : 8);
      total = SAMPLES_PER_READING + $urandom_range(0, 49);
      pause_at = $urandom_range(1, total - 1);
      while (total > 0) begin
        case ($urandom_range(0, 3))
          0: noise = 0;
          1: noise = 16;
          2: noise = 200;
          default: noise = SAMPLE_MAX + 1;
        endcase
        lo = $urandom_range(0, SAMPLE_MAX);
        hi = $urandom_range(1, (total < 60) ? total : 60);
        send_samples(hi, lo, noise);
        total -= hi;
        if (pause_at > total && pause_at <= total + hi) drain();
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_equal_bounds();
    test_inverted_bounds();
    test_min_calibration();
    test_max_calibration();
    test_level_saturation();
    test_spare_mode();
    test_register_reload();
    test_random_phases();
    drain();
    if (error_count == 0) begin
      $display("rssi_average_calibrate_percent_tb: PASS");
    end else begin
      $display("rssi_average_calibrate_percent_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("%0t: timeout", $time);
    $display("rssi_average_calibrate_percent_tb: FAIL");
    $finish;
  end

endmodule

@@ rssi_average_calibrate_percent.f @@
src/rac_pkg.sv
src/rac_div.sv
src/rssi_average_calibrate_percent.sv
tb/rssi_average_calibrate_percent_tb.sv
